@@ hw/rtl/utnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP TX node resolver package
// Shared types, codes and helpers for the node resolver and its submodules.
// ----------------------------------------------------------------------------
package utnr_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_META   = 2'd0,
        OP_DATA   = 2'd1,
        OP_REPLY  = 2'd2,
        OP_INVAL  = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_SOCKET = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_EVENT  = 2'd3
    } t_kind;

    // Event codes
    typedef enum logic [2:0] {
        EV_DEST_UNKNOWN = 3'd0,
        EV_PORT_FIX     = 3'd1,
        EV_LAST_NODE    = 3'd2,
        EV_LAST_PORT    = 3'd3,
        EV_SENT         = 3'd4
    } t_event;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOCAL_IP     = 2'd0;
    localparam logic [1:0] CFG_MAX_NODE     = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_PORT = 2'd2;

    // Configuration reset values
    localparam logic [31:0] RST_LOCAL_IP     = 32'd0;
    localparam logic [7:0]  RST_MAX_NODE     = 8'd127;
    localparam logic [15:0] RST_DEFAULT_PORT = 16'd2718;

    // Result slots of one run, in emission order (one-hot)
    localparam logic [7:0] SLOT_PORT_FIX  = 8'b0000_0001;
    localparam logic [7:0] SLOT_UNKNOWN   = 8'b0000_0010;
    localparam logic [7:0] SLOT_LOOKUP    = 8'b0000_0100;
    localparam logic [7:0] SLOT_LAST_NODE = 8'b0000_1000;
    localparam logic [7:0] SLOT_LAST_PORT = 8'b0001_0000;
    localparam logic [7:0] SLOT_SOCKET    = 8'b0010_0000;
    localparam logic [7:0] SLOT_SENT      = 8'b0100_0000;
    localparam logic [7:0] SLOT_DATA      = 8'b1000_0000;

    // One input transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  dest_node;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_len;
        logic [63:0] word_data;
        logic [7:0]  word_keep;
        logic        word_last;
        logic [31:0] reply_addr;
    } t_item;

    // Configuration registers
    typedef struct packed {
        logic [31:0] local_ip_addr;
        logic [7:0]  max_node_id;
        logic [15:0] default_port;
    } t_cfg;

    // Run of results caused by one item: slot mask plus shared fields
    typedef struct packed {
        logic [7:0]  mask;
        logic [63:0] data;
        logic [7:0]  keep;
        logic        last;
        logic [31:0] src_addr;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [15:0] dport;
        logic [15:0] length;
        logic [7:0]  node;
    } t_desc;

    // One result transaction
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [63:0] out_data;
        logic [7:0]  out_keep;
        logic        out_last;
        logic [31:0] src_addr;
        logic [15:0] src_port_out;
        logic [31:0] dst_addr;
        logic [15:0] dst_port_out;
        logic [15:0] length_out;
        logic [2:0]  event_code;
        logic [15:0] tag_value;
        logic        run_end;
    } t_res;

    // Count set bits of a byte mask
    function automatic logic [3:0] f_popcount(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/utnr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP TX node resolver core
// Holds the packet phase, the one-entry node cache and the pending socket
// fields; turns one registered item into a run descriptor in a single pass.
// ----------------------------------------------------------------------------
module utnr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_proc,
    input  utnr_pkg::t_item   i_item,
    input  utnr_pkg::t_cfg    i_cfg,
    output logic              o_load,
    output utnr_pkg::t_desc   o_desc
);

    typedef enum logic [3:0] {
        PH_META  = 4'b0001,
        PH_REPLY = 4'b0010,
        PH_ACC   = 4'b0100,
        PH_DROP  = 4'b1000
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic        r_cache_valid,  n_cache_valid;
    logic [7:0]  r_cached_node,  n_cached_node;
    logic [31:0] r_cached_addr,  n_cached_addr;
    logic [15:0] r_expected_len, n_expected_len;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [7:0]  r_pending_node, n_pending_node;
    logic [15:0] r_pending_sp,   n_pending_sp;
    logic [15:0] r_pending_dp,   n_pending_dp;
    logic        r_inv_pending,  n_inv_pending;

    logic        w_deliver;
    logic [31:0] w_deliver_addr;
    logic        w_cache_live;
    logic [15:0] w_sp;
    logic [15:0] w_dp;
    logic [15:0] w_bc_sum;
    logic        w_last;
    utnr_pkg::t_desc w_desc;

    // Byte count after the current word
    assign w_bc_sum = r_byte_count + {12'd0, utnr_pkg::f_popcount(i_item.word_keep)};

    // Decode the item, update state and build its result run
    always_comb begin
        n_phase        = r_phase;
        n_cache_valid  = r_cache_valid;
        n_cached_node  = r_cached_node;
        n_cached_addr  = r_cached_addr;
        n_expected_len = r_expected_len;
        n_byte_count   = r_byte_count;
        n_pending_node = r_pending_node;
        n_pending_sp   = r_pending_sp;
        n_pending_dp   = r_pending_dp;
        n_inv_pending  = r_inv_pending;
        w_deliver      = 1'b0;
        w_deliver_addr = r_cached_addr;
        w_cache_live   = r_cache_valid & ~r_inv_pending;
        w_sp           = (i_item.source_port == 16'd0) ? i_cfg.default_port
                                                       : i_item.source_port;
        w_dp           = (i_item.dest_port == 16'd0) ? i_cfg.default_port
                                                     : i_item.dest_port;
        w_last         = i_item.word_last |
                         ((r_expected_len != 16'd0) && (w_bc_sum >= r_expected_len));
        w_desc         = '0;

        if (i_proc) begin
            unique case (utnr_pkg::t_op'(i_item.operation))
                utnr_pkg::OP_INVAL: begin
                    if (r_phase == PH_META) begin
                        n_cache_valid = 1'b0;
                    end else begin
                        n_inv_pending = 1'b1;
                    end
                end
                utnr_pkg::OP_META: begin
                    if (r_phase == PH_META) begin
                        // apply a deferred invalidate before the lookup
                        if (r_inv_pending) begin
                            n_cache_valid = 1'b0;
                            n_inv_pending = 1'b0;
                        end
                        n_expected_len = i_item.payload_len;
                        n_byte_count   = 16'd0;
                        n_pending_node = i_item.dest_node;
                        if (i_item.dest_node > i_cfg.max_node_id) begin
                            w_desc.mask = utnr_pkg::SLOT_UNKNOWN;
                            n_phase     = PH_DROP;
                        end else begin
                            n_pending_sp = w_sp;
                            n_pending_dp = w_dp;
                            if (i_item.dest_port == 16'd0) begin
                                w_desc.mask = utnr_pkg::SLOT_PORT_FIX;
                            end
                            if (w_cache_live && (r_cached_node == i_item.dest_node)) begin
                                w_deliver      = 1'b1;
                                w_deliver_addr = r_cached_addr;
                            end else begin
                                w_desc.mask = w_desc.mask | utnr_pkg::SLOT_LOOKUP;
                                n_phase     = PH_REPLY;
                            end
                        end
                    end
                end
                utnr_pkg::OP_REPLY: begin
                    if (r_phase == PH_REPLY) begin
                        n_cached_node  = r_pending_node;
                        n_cached_addr  = i_item.reply_addr;
                        n_cache_valid  = 1'b1;
                        w_deliver      = 1'b1;
                        w_deliver_addr = i_item.reply_addr;
                    end
                end
                utnr_pkg::OP_DATA: begin
                    if ((r_phase == PH_ACC) || (r_phase == PH_DROP)) begin
                        n_byte_count = w_bc_sum;
                        if (r_phase == PH_ACC) begin
                            w_desc.mask = utnr_pkg::SLOT_DATA;
                        end
                        if (w_last) begin
                            n_phase = PH_META;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Resolved address: send the socket or drop on a zero address
            if (w_deliver) begin
                if (w_deliver_addr == 32'd0) begin
                    w_desc.mask = w_desc.mask | utnr_pkg::SLOT_UNKNOWN;
                    n_phase     = PH_DROP;
                end else begin
                    w_desc.mask = w_desc.mask | utnr_pkg::SLOT_LAST_NODE |
                                  utnr_pkg::SLOT_LAST_PORT | utnr_pkg::SLOT_SOCKET |
                                  utnr_pkg::SLOT_SENT;
                    n_phase     = PH_ACC;
                end
            end
        end

        w_desc.data     = i_item.word_data;
        w_desc.keep     = i_item.word_keep;
        w_desc.last     = w_last;
        w_desc.src_addr = i_cfg.local_ip_addr;
        w_desc.sport    = n_pending_sp;
        w_desc.dst_addr = w_deliver_addr;
        w_desc.dport    = n_pending_dp;
        w_desc.length   = n_expected_len;
        w_desc.node     = n_pending_node;
    end

    assign o_load = i_proc && (w_desc.mask != 8'd0);
    assign o_desc = w_desc;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_META;
            r_cache_valid <= 1'b0;
            r_inv_pending <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cache_valid <= n_cache_valid;
            r_inv_pending <= n_inv_pending;
        end
    end

    // Cache and pending packet fields
    always_ff @(posedge i_clk) begin
        r_cached_node  <= n_cached_node;
        r_cached_addr  <= n_cached_addr;
        r_expected_len <= n_expected_len;
        r_byte_count   <= n_byte_count;
        r_pending_node <= n_pending_node;
        r_pending_sp   <= n_pending_sp;
        r_pending_dp   <= n_pending_dp;
    end

endmodule

@@ hw/rtl/utnr_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP TX node resolver result walker
// Holds one run descriptor and sends its results, one per cycle unless stalled,
// in slot order through the output register.
// ----------------------------------------------------------------------------
module utnr_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  utnr_pkg::t_desc   i_desc,
    output logic              o_desc_free,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output utnr_pkg::t_res    o_res
);

    logic [7:0]      r_mask;
    utnr_pkg::t_desc r_desc;
    logic            r_out_valid;
    utnr_pkg::t_res  r_res;

    logic [7:0]      w_pick;
    logic [7:0]      w_rest;
    logic            w_out_free;
    logic            w_advance;
    utnr_pkg::t_res  w_res;

    // Pick the lowest pending slot
    assign w_pick      = r_mask & (~r_mask + 8'd1);
    assign w_rest      = r_mask & ~w_pick;
    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign w_advance   = (r_mask != 8'd0) & w_out_free;
    assign o_desc_free = (r_mask == 8'd0) | (w_advance & (w_rest == 8'd0));

    // Format the picked result, unused fields zero
    always_comb begin
        w_res         = '0;
        w_res.run_end = (w_rest == 8'd0);
        unique case (w_pick)
            utnr_pkg::SLOT_PORT_FIX: begin
                w_res.result_kind = utnr_pkg::KIND_EVENT;
                w_res.event_code  = utnr_pkg::EV_PORT_FIX;
                w_res.tag_value   = 16'd1;
            end
            utnr_pkg::SLOT_UNKNOWN: begin
                w_res.result_kind = utnr_pkg::KIND_EVENT;
                w_res.event_code  = utnr_pkg::EV_DEST_UNKNOWN;
                w_res.tag_value   = 16'd1;
            end
            utnr_pkg::SLOT_LOOKUP: begin
                w_res.result_kind = utnr_pkg::KIND_LOOKUP;
                w_res.tag_value   = {8'd0, r_desc.node};
            end
            utnr_pkg::SLOT_LAST_NODE: begin
                w_res.result_kind = utnr_pkg::KIND_EVENT;
                w_res.event_code  = utnr_pkg::EV_LAST_NODE;
                w_res.tag_value   = {8'd0, r_desc.node};
            end
            utnr_pkg::SLOT_LAST_PORT: begin
                w_res.result_kind = utnr_pkg::KIND_EVENT;
                w_res.event_code  = utnr_pkg::EV_LAST_PORT;
                w_res.tag_value   = r_desc.dport;
            end
            utnr_pkg::SLOT_SOCKET: begin
                w_res.result_kind  = utnr_pkg::KIND_SOCKET;
                w_res.src_addr     = r_desc.src_addr;
                w_res.src_port_out = r_desc.sport;
                w_res.dst_addr     = r_desc.dst_addr;
                w_res.dst_port_out = r_desc.dport;
                w_res.length_out   = r_desc.length;
            end
            utnr_pkg::SLOT_SENT: begin
                w_res.result_kind = utnr_pkg::KIND_EVENT;
                w_res.event_code  = utnr_pkg::EV_SENT;
                w_res.tag_value   = 16'd1;
            end
            utnr_pkg::SLOT_DATA: begin
                w_res.result_kind = utnr_pkg::KIND_DATA;
                w_res.out_data    = r_desc.data;
                w_res.out_keep    = r_desc.keep;
                w_res.out_last    = r_desc.last;
            end
            default: begin
            end
        endcase
    end

    // Slot mask and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_desc.mask;
            end else if (w_advance) begin
                r_mask <= w_rest;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Descriptor fields and output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

@@ hw/rtl/udp_tx_node_resolver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP TX node resolver
// Resolves fabric node numbers to IPv4 addresses through a one-entry cache
// or lookup requests, and emits socket metadata, events and payload words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_operation .. i_reply_addr
//  out       output     o_out_valid / i_out_stall  o_result_kind .. o_run_end
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  An item goes input register -> core (one pass) -> result walker -> output
//  register. The walker sends one result per cycle while i_out_stall is low, so
//  an item with k results (1 to 5) holds it until the last of them is out;
//  items with one or no result flow every cycle while the output is free.
//  Synchronous active-low reset clears phase, cache valid, pending invalidate,
//  slot mask and valid flags; o_in_stall rises only while the walker is busy.
// ----------------------------------------------------------------------------
module udp_tx_node_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_dest_node,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_payload_len,
    input  logic [63:0] i_word_data,
    input  logic [7:0]  i_word_keep,
    input  logic        i_word_last,
    input  logic [31:0] i_reply_addr,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_out_data,
    output logic [7:0]  o_out_keep,
    output logic        o_out_last,
    output logic [31:0] o_src_addr,
    output logic [15:0] o_src_port_out,
    output logic [31:0] o_dst_addr,
    output logic [15:0] o_dst_port_out,
    output logic [15:0] o_length_out,
    output logic [2:0]  o_event_code,
    output logic [15:0] o_tag_value,
    output logic        o_run_end,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    utnr_pkg::t_cfg  r_cfg;
    logic            r_in_valid;
    utnr_pkg::t_item r_item;

    logic            w_in_accept;
    logic            w_proc;
    logic            w_desc_free;
    logic            w_load;
    utnr_pkg::t_desc w_desc;
    utnr_pkg::t_res  w_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_ip_addr <= utnr_pkg::RST_LOCAL_IP;
            r_cfg.max_node_id   <= utnr_pkg::RST_MAX_NODE;
            r_cfg.default_port  <= utnr_pkg::RST_DEFAULT_PORT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                utnr_pkg::CFG_LOCAL_IP:     r_cfg.local_ip_addr <= i_cfg_data;
                utnr_pkg::CFG_MAX_NODE:     r_cfg.max_node_id   <= i_cfg_data[7:0];
                utnr_pkg::CFG_DEFAULT_PORT: r_cfg.default_port  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the transaction until the core takes it
    assign w_proc      = r_in_valid & w_desc_free;
    assign o_in_stall  = r_in_valid & ~w_desc_free;
    assign w_in_accept = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.operation   <= i_operation;
            r_item.dest_node   <= i_dest_node;
            r_item.source_port <= i_source_port;
            r_item.dest_port   <= i_dest_port;
            r_item.payload_len <= i_payload_len;
            r_item.word_data   <= i_word_data;
            r_item.word_keep   <= i_word_keep;
            r_item.word_last   <= i_word_last;
            r_item.reply_addr  <= i_reply_addr;
        end
    end

    utnr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (w_proc),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_load  (w_load),
        .o_desc  (w_desc)
    );

    utnr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_desc      (w_desc),
        .o_desc_free (w_desc_free),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    // Output ports
    assign o_result_kind  = w_res.result_kind;
    assign o_out_data     = w_res.out_data;
    assign o_out_keep     = w_res.out_keep;
    assign o_out_last     = w_res.out_last;
    assign o_src_addr     = w_res.src_addr;
    assign o_src_port_out = w_res.src_port_out;
    assign o_dst_addr     = w_res.dst_addr;
    assign o_dst_port_out = w_res.dst_port_out;
    assign o_length_out   = w_res.length_out;
    assign o_event_code   = w_res.event_code;
    assign o_tag_value    = w_res.tag_value;
    assign o_run_end      = w_res.run_end;

    // Socket metadata is always followed by the packet sent event
    a_socket_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == utnr_pkg::KIND_SOCKET)) |-> !o_run_end)
        else $error("socket metadata closed its run");

    // A lookup request and a data word each close their run
    a_lookup_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_result_kind == utnr_pkg::KIND_LOOKUP) ||
                         (o_result_kind == utnr_pkg::KIND_DATA))) |-> o_run_end)
        else $error("lookup request or data word did not close its run");

    // After socket metadata the next result is the packet sent event
    a_sent_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_result_kind == utnr_pkg::KIND_SOCKET))
        |=> (o_out_valid && (o_result_kind == utnr_pkg::KIND_EVENT) &&
             (o_event_code == utnr_pkg::EV_SENT)))
        else $error("packet sent event did not follow socket metadata");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP TX node resolver testbench
// Drives metadata, data words, lookup replies and cache invalidations through
// the stall handshake, and predicts every result from a local copy of the
// resolver state and registers. Each result is checked field by field in
// order. Directed tests cover reset defaults, the node limit, port defaults,
// zero addresses, invalidation and ignored items. Random traffic follows the
// packet flow under several register settings with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 70;

    // Phases of the packet flow as the predictor tracks them
    typedef enum logic [3:0] {
        PH_WAIT_META  = 4'b0001,
        PH_WAIT_REPLY = 4'b0010,
        PH_FORWARD    = 4'b0100,
        PH_DISCARD    = 4'b1000
    } t_phase;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    utnr_pkg::t_item in_item = '0;
    logic            out_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [1:0]      cfg_index = utnr_pkg::CFG_LOCAL_IP;
    logic [31:0]     cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_result_kind;
    logic [63:0] o_out_data;
    logic [7:0]  o_out_keep;
    logic        o_out_last;
    logic [31:0] o_src_addr;
    logic [15:0] o_src_port_out;
    logic [31:0] o_dst_addr;
    logic [15:0] o_dst_port_out;
    logic [15:0] o_length_out;
    logic [2:0]  o_event_code;
    logic [15:0] o_tag_value;
    logic        o_run_end;
    logic        o_cfg_ready;

    // Predicted resolver state and register copies
    t_phase      st_phase = PH_WAIT_META;
    logic        hit_valid = 1'b0;
    logic [7:0]  hit_node = '0;
    logic [31:0] hit_addr = '0;
    logic [15:0] pkt_len = '0;
    logic [15:0] pkt_bytes = '0;
    logic [7:0]  pkt_node = '0;
    logic [15:0] pkt_sport = '0;
    logic [15:0] pkt_dport = '0;
    logic        flush_pending = 1'b0;
    logic [31:0] cfg_ip = utnr_pkg::RST_LOCAL_IP;
    logic [7:0]  cfg_max_node = utnr_pkg::RST_MAX_NODE;
    logic [15:0] cfg_dflt_port = utnr_pkg::RST_DEFAULT_PORT;

    utnr_pkg::t_res run_q[$];
    utnr_pkg::t_res expected_q[$];

    bit          idle_on = 1'b1;
    int unsigned out_hold = 0;
    int unsigned err_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    udp_tx_node_resolver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (in_item.operation),
        .i_dest_node    (in_item.dest_node),
        .i_source_port  (in_item.source_port),
        .i_dest_port    (in_item.dest_port),
        .i_payload_len  (in_item.payload_len),
        .i_word_data    (in_item.word_data),
        .i_word_keep    (in_item.word_keep),
        .i_word_last    (in_item.word_last),
        .i_reply_addr   (in_item.reply_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_result_kind  (o_result_kind),
        .o_out_data     (o_out_data),
        .o_out_keep     (o_out_keep),
        .o_out_last     (o_out_last),
        .o_src_addr     (o_src_addr),
        .o_src_port_out (o_src_port_out),
        .o_dst_addr     (o_dst_addr),
        .o_dst_port_out (o_dst_port_out),
        .o_length_out   (o_length_out),
        .o_event_code   (o_event_code),
        .o_tag_value    (o_tag_value),
        .o_run_end      (o_run_end),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic utnr_pkg::t_res blank_res(utnr_pkg::t_kind kind);
        utnr_pkg::t_res r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

    task automatic add_event(utnr_pkg::t_event code, logic [15:0] tag);
        utnr_pkg::t_res r;
        r = blank_res(utnr_pkg::KIND_EVENT);
        r.event_code = code;
        r.tag_value = tag;
        run_q.push_back(r);
    endtask

    // Emit socket metadata for a resolved address, or drop on address zero
    task automatic emit_socket(logic [31:0] addr);
        utnr_pkg::t_res r;
        if (addr == '0) begin
            add_event(utnr_pkg::EV_DEST_UNKNOWN, 16'd1);
            st_phase = PH_DISCARD;
        end else begin
            add_event(utnr_pkg::EV_LAST_NODE, {8'd0, pkt_node});
            add_event(utnr_pkg::EV_LAST_PORT, pkt_dport);
            r = blank_res(utnr_pkg::KIND_SOCKET);
            r.src_addr = cfg_ip;
            r.src_port_out = pkt_sport;
            r.dst_addr = addr;
            r.dst_port_out = pkt_dport;
            r.length_out = pkt_len;
            run_q.push_back(r);
            add_event(utnr_pkg::EV_SENT, 16'd1);
            st_phase = PH_FORWARD;
        end
    endtask

    // Advance the predicted state by one transaction and queue its results
    task automatic resolve_item(input utnr_pkg::t_item it, output bit used);
        utnr_pkg::t_res r;
        logic [15:0]    sp;
        logic [15:0]    dp;
        logic           last;
        used = 1'b0;
        run_q.delete();
        case (it.operation)
            utnr_pkg::OP_INVAL: begin
                used = 1'b1;
                if (st_phase == PH_WAIT_META) begin
                    hit_valid = 1'b0;
                    hit_node = '0;
                    hit_addr = '0;
                end else begin
                    flush_pending = 1'b1;
                end
            end
            utnr_pkg::OP_META: begin
                if (st_phase == PH_WAIT_META) begin
                    used = 1'b1;
                    if (flush_pending) begin
                        hit_valid = 1'b0;
                        hit_node = '0;
                        hit_addr = '0;
                        flush_pending = 1'b0;
                    end
                    pkt_len = it.payload_len;
                    pkt_bytes = '0;
                    pkt_node = it.dest_node;
                    if (it.dest_node > cfg_max_node) begin
                        add_event(utnr_pkg::EV_DEST_UNKNOWN, 16'd1);
                        st_phase = PH_DISCARD;
                    end else begin
                        sp = (it.source_port == '0) ? cfg_dflt_port : it.source_port;
                        dp = it.dest_port;
                        if (dp == '0) begin
                            dp = cfg_dflt_port;
                            add_event(utnr_pkg::EV_PORT_FIX, 16'd1);
                        end
                        pkt_sport = sp;
                        pkt_dport = dp;
                        if (hit_valid && hit_node == it.dest_node) begin
                            emit_socket(hit_addr);
                        end else begin
                            r = blank_res(utnr_pkg::KIND_LOOKUP);
                            r.tag_value = {8'd0, it.dest_node};
                            run_q.push_back(r);
                            st_phase = PH_WAIT_REPLY;
                        end
                    end
                end
            end
            utnr_pkg::OP_REPLY: begin
                if (st_phase == PH_WAIT_REPLY) begin
                    used = 1'b1;
                    hit_node = pkt_node;
                    hit_addr = it.reply_addr;
                    hit_valid = 1'b1;
                    emit_socket(it.reply_addr);
                end
            end
            utnr_pkg::OP_DATA: begin
                if (st_phase == PH_FORWARD || st_phase == PH_DISCARD) begin
                    used = 1'b1;
                    for (int b = 0; b < 8; b++) begin
                        pkt_bytes = pkt_bytes + {15'd0, it.word_keep[b]};
                    end
                    last = it.word_last;
                    if (pkt_len != '0 && pkt_bytes >= pkt_len) begin
                        last = 1'b1;
                    end
                    if (st_phase == PH_FORWARD) begin
                        r = blank_res(utnr_pkg::KIND_DATA);
                        r.out_data = it.word_data;
                        r.out_keep = it.word_keep;
                        r.out_last = last;
                        run_q.push_back(r);
                    end
                    if (last) begin
                        st_phase = PH_WAIT_META;
                    end
                end
            end
        endcase
        // Mark the last result of this transaction
        if (run_q.size() != 0) begin
            r = run_q.pop_back();
            r.run_end = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i]) begin
            expected_q.push_back(run_q[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Send one transaction, after a random gap while idling is on; valid stays
    // high after the accept so that a following item can go out back to back
    task automatic send_item(input utnr_pkg::t_item it, output bit used);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        resolve_item(it, used);
        if (used) items_sent++;
    endtask

    task automatic push_item(input utnr_pkg::t_item it);
        bit used;
        send_item(it, used);
    endtask

    // Drop valid, wait until every expected result is out, then let the
    // pipeline empty of items that cause no result
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            utnr_pkg::CFG_LOCAL_IP:     cfg_ip = val;
            utnr_pkg::CFG_MAX_NODE:     cfg_max_node = val[7:0];
            utnr_pkg::CFG_DEFAULT_PORT: cfg_dflt_port = val[15:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic utnr_pkg::t_item mk_meta(logic [7:0] node, logic [15:0] sp,
                                                logic [15:0] dp, logic [15:0] len);
        utnr_pkg::t_item it;
        it = '0;
        it.operation = utnr_pkg::OP_META;
        it.dest_node = node;
        it.source_port = sp;
        it.dest_port = dp;
        it.payload_len = len;
        return it;
    endfunction

    function automatic utnr_pkg::t_item mk_data(logic [63:0] data, logic [7:0] keep,
                                                logic last);
        utnr_pkg::t_item it;
        it = '0;
        it.operation = utnr_pkg::OP_DATA;
        it.word_data = data;
        it.word_keep = keep;
        it.word_last = last;
        return it;
    endfunction

    function automatic utnr_pkg::t_item mk_reply(logic [31:0] addr);
        utnr_pkg::t_item it;
        it = '0;
        it.operation = utnr_pkg::OP_REPLY;
        it.reply_addr = addr;
        return it;
    endfunction

    function automatic utnr_pkg::t_item mk_inval();
        utnr_pkg::t_item it;
        it = '0;
        it.operation = utnr_pkg::OP_INVAL;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    task automatic report(string msg);
        if (err_count < 100) $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic cmp_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
        end
    endtask

    // Hold the output stalled for the length picked for each accepted result
    always @(negedge i_clk) begin
        if (out_hold != 0) begin
            out_stall <= 1'b1;
            out_hold = out_hold - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        utnr_pkg::t_res want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            out_hold = idle_on ? $urandom_range(0, 15) : 0;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %0d of kind %0d",
                                 results_seen, o_result_kind));
            end else begin
                want = expected_q.pop_front();
                cmp_field("result_kind", 64'(o_result_kind), 64'(want.result_kind));
                cmp_field("out_data", o_out_data, want.out_data);
                cmp_field("out_keep", 64'(o_out_keep), 64'(want.out_keep));
                cmp_field("out_last", 64'(o_out_last), 64'(want.out_last));
                cmp_field("src_addr", 64'(o_src_addr), 64'(want.src_addr));
                cmp_field("src_port_out", 64'(o_src_port_out), 64'(want.src_port_out));
                cmp_field("dst_addr", 64'(o_dst_addr), 64'(want.dst_addr));
                cmp_field("dst_port_out", 64'(o_dst_port_out), 64'(want.dst_port_out));
                cmp_field("length_out", 64'(o_length_out), 64'(want.length_out));
                cmp_field("event_code", 64'(o_event_code), 64'(want.event_code));
                cmp_field("tag_value", 64'(o_tag_value), 64'(want.tag_value));
                cmp_field("run_end", 64'(o_run_end), 64'(want.run_end));
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset register values: default port, node limit 127, source address 0
    task automatic test_reset_defaults();
        push_item(mk_meta(8'd127, 16'd0, 16'd0, 16'd10));
        push_item(mk_reply(32'h0A00_0001));
        push_item(mk_data(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0));
        push_item(mk_data(64'h0123_4567_89AB_CDEF, 8'h0F, 1'b0));
        push_item(mk_meta(8'd128, 16'd5, 16'd6, 16'd0));
        push_item(mk_data(64'd0, 8'hFF, 1'b1));
    endtask

    // Register extremes, node above the limit, ports kept when nonzero
    task automatic test_node_limit_and_ports();
        settle();
        write_reg(utnr_pkg::CFG_LOCAL_IP, 32'hFFFF_FFFF);
        write_reg(utnr_pkg::CFG_MAX_NODE, 32'd0);
        write_reg(utnr_pkg::CFG_DEFAULT_PORT, 32'h0000_FFFF);
        push_item(mk_meta(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_item(mk_reply(32'hFFFF_FFFF));
        push_item(mk_data(64'h8000_0000_0000_0001, 8'h00, 1'b1));
        push_item(mk_meta(8'd255, 16'd0, 16'd0, 16'd8));
        push_item(mk_data(64'hDEAD_BEEF_0000_0000, 8'hFF, 1'b0));
    endtask

    // Zero reply address, then the cached zero address on a hit
    task automatic test_zero_address();
        settle();
        write_reg(utnr_pkg::CFG_MAX_NODE, 32'd255);
        push_item(mk_meta(8'd255, 16'd0, 16'd1, 16'd0));
        push_item(mk_reply(32'd0));
        push_item(mk_data(64'h1, 8'hFF, 1'b1));
        push_item(mk_meta(8'd255, 16'd7, 16'd0, 16'd0));
        push_item(mk_data(64'h2, 8'h01, 1'b1));
    endtask

    // Deferred and immediate invalidation, and items in the wrong phase
    task automatic test_invalidate_and_ignored();
        push_item(mk_meta(8'd255, 16'd3, 16'd4, 16'd0));
        push_item(mk_inval());
        push_item(mk_data(64'h3, 8'hAA, 1'b1));
        push_item(mk_meta(8'd255, 16'd3, 16'd4, 16'd20));
        push_item(mk_meta(8'd9, 16'd1, 16'd1, 16'd1));
        push_item(mk_data(64'h4, 8'hFF, 1'b1));
        push_item(mk_reply(32'h0102_0304));
        push_item(mk_reply(32'h0506_0708));
        push_item(mk_data(64'h5, 8'h55, 1'b1));
        push_item(mk_data(64'h6, 8'hFF, 1'b1));
        push_item(mk_reply(32'h0909_0909));
        push_item(mk_meta(8'd255, 16'd3, 16'd4, 16'd0));
        push_item(mk_data(64'h7, 8'hFF, 1'b1));
        push_item(mk_inval());
        push_item(mk_meta(8'd255, 16'd3, 16'd4, 16'd0));
        push_item(mk_reply(32'h0000_0005));
        push_item(mk_data(64'h8, 8'hFF, 1'b1));
    endtask

    // Packet flows with random content under several register settings,
    // mixed with random noise items
    task automatic test_random_traffic();
        utnr_pkg::t_item it;
        bit              used;
        int unsigned     n;
        int unsigned     k;
        int unsigned     words_in_pkt;
        words_in_pkt = 0;
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(utnr_pkg::CFG_LOCAL_IP, $urandom());
                    write_reg(utnr_pkg::CFG_MAX_NODE, 32'd127);
                    write_reg(utnr_pkg::CFG_DEFAULT_PORT, $urandom_range(1, 65535));
                end
                1: begin
                    write_reg(utnr_pkg::CFG_LOCAL_IP, 32'd0);
                    write_reg(utnr_pkg::CFG_MAX_NODE, 32'd255);
                    write_reg(utnr_pkg::CFG_DEFAULT_PORT, 32'd0);
                end
                2: begin
                    write_reg(utnr_pkg::CFG_LOCAL_IP, 32'hFFFF_FFFF);
                    write_reg(utnr_pkg::CFG_MAX_NODE, 32'd0);
                    write_reg(utnr_pkg::CFG_DEFAULT_PORT, 32'h0000_FFFF);
                end
                default: begin
                    write_reg(utnr_pkg::CFG_LOCAL_IP, $urandom());
                    write_reg(utnr_pkg::CFG_MAX_NODE, $urandom_range(1, 254));
                    write_reg(utnr_pkg::CFG_DEFAULT_PORT, $urandom_range(0, 65535));
                end
            endcase
            n = 0;
            k = 0;
            while (n < RAND_PER_PHASE) begin
                // Pick stretches with and without idling at random
                if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
                k++;
                it.operation = 2'($urandom_range(0, 3));
                it.dest_node = 8'($urandom_range(0, 255));
                it.source_port = 16'($urandom_range(0, 65535));
                it.dest_port = 16'($urandom_range(0, 65535));
                it.payload_len = 16'($urandom_range(0, 65535));
                it.word_data = {$urandom(), $urandom()};
                it.word_keep = 8'($urandom_range(0, 255));
                it.word_last = 1'($urandom_range(0, 1));
                it.reply_addr = $urandom();
                // Most items follow the packet flow; the rest stay as noise
                if ($urandom_range(0, 9) != 0) begin
                    case (st_phase)
                        PH_WAIT_META: begin
                            it.operation = utnr_pkg::OP_META;
                            case ($urandom_range(0, 9)) inside
                                [0:5]:   it.dest_node = 8'($urandom_range(0, 3));
                                [6:7]:   it.dest_node = cfg_max_node;
                                default: ;
                            endcase
                            if ($urandom_range(0, 3) == 0) it.source_port = '0;
                            if ($urandom_range(0, 3) == 0) it.dest_port = '0;
                            case ($urandom_range(0, 7)) inside
                                [0:1]:   it.payload_len = '0;
                                7:       ;
                                default: it.payload_len = 16'($urandom_range(1, 48));
                            endcase
                            words_in_pkt = 0;
                        end
                        PH_WAIT_REPLY: begin
                            it.operation = utnr_pkg::OP_REPLY;
                            if ($urandom_range(0, 7) == 0) it.reply_addr = '0;
                        end
                        default: begin
                            it.operation = utnr_pkg::OP_DATA;
                            if ($urandom_range(0, 1) == 0) it.word_keep = 8'hFF;
                            it.word_last = (words_in_pkt >= 15) ||
                                           ($urandom_range(0, 9) == 0);
                            words_in_pkt++;
                        end
                    endcase
                end
                send_item(it, used);
                if (used) n++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = ($urandom_range(0, 1) != 0);
        test_reset_defaults();
        test_node_limit_and_ports();
        test_zero_address();
        test_invalidate_and_ignored();
        test_random_traffic();
        settle();
        $display("Run covered %0d items, %0d results and %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with cache hits and misses, drops, port defaults and invalidation.");
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches found", err_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ udp_tx_node_resolver.f @@
hw/rtl/utnr_pkg.sv
hw/rtl/utnr_core.sv
hw/rtl/utnr_emit.sv
hw/rtl/udp_tx_node_resolver.sv
verif/tb.sv
